/* sv/integer_to_radix_digits_top_defines.svh */
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define IRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/ird_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ird_pkg;

  localparam int DIG_W       = 6;
  localparam int CHAR_W      = 8;
  localparam int STAT_W      = 2;
  localparam int RADIX_W     = 7;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int MAX_RESULTS = 64;

  typedef logic [DIG_W-1:0]  digit_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_CFG  = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  // register index codes
  localparam logic REG_RADIX = 1'b0;
  localparam logic REG_QMUL  = 1'b1;

  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_A     = 8'h41;

  function automatic char_t digit_to_char(input digit_t d);
    char_t c;
    if (d < digit_t'(10)) begin
      c = CH_ZERO + {2'b00, d};
    end else begin
      c = CH_A + {2'b00, d} - char_t'(10);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/ird_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_digits_top_defines.svh"

module ird_divider
  import ird_pkg::*;
#(
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire digit_t       divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output digit_t            remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  digit_t        rem_r, rem_nxt;
  digit_t        dvs_r, dvs_nxt;

  logic [DIG_W:0] trial;
  logic [DIG_W:0] diff;
  logic           ge;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem_r, quo_r[W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[W-2:0], ge};
      rem_nxt = ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `IRD_ASSERT_IMPL(a_no_restart, clk, rst_n, busy_r, !start)
  `IRD_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, busy_r, rem_r < dvs_r)
  `IRD_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)

endmodule

`default_nettype wire

/* sv/ird_digit_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module ird_digit_buf
  import ird_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire digit_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output digit_t             rd_data
);

  digit_t mem [DEPTH];
  digit_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/integer_to_radix_digits_top.sv */
// per digit: the shared restoring divider (one quotient bit per cycle) plus check,
//   correct and multiply; the results then leave the digit buffer, each through a
//   buffer read and a load into the output register
// throughput: one request at a time, the next is taken once the final result
//   of the current one sits in the output register
// reset: synchronous active-low, radix 10, quotient multiplier 1, no result pending
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_digits_top_defines.svh"

module integer_to_radix_digits_top
  import ird_pkg::*;
#(
  parameter int MAX_DIGITS  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CHAR_W-1:0]           out_digit_char,
  output logic                        out_last,
  output logic [STAT_W-1:0]           out_status,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_AW-1:0]      paddr,
  input  wire logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]           prdata,
  output logic                        pready
);

  // magnitude register: wide enough for |value| and for radix squared,
  // which bounds any quotient times multiplier
  localparam int MAG_W = (VALUE_WIDTH + 1 > 12) ? VALUE_WIDTH + 1 : 12;
  localparam int ND_W  = $clog2(MAX_DIGITS + 1);
  localparam int AW    = $clog2(MAX_DIGITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_LD    = 3'd6;
  localparam logic [2:0] S_ONE   = 3'd7;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [RADIX_W-1:0] radix_r, qmul_r;
  logic               cfg_wr;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_W'(10);
      qmul_r  <= RADIX_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RADIX: radix_r <= pwdata[RADIX_W-1:0];
        REG_QMUL:  qmul_r  <= pwdata[RADIX_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RADIX: prdata = {{(CFG_DW-RADIX_W){radix_r[RADIX_W-1]}}, radix_r};
      REG_QMUL:  prdata = {{(CFG_DW-RADIX_W){qmul_r[RADIX_W-1]}}, qmul_r};
    endcase
  end

  // magnitudes and signs of the configuration
  logic               rneg, mneg, cfg_bad;
  logic [RADIX_W-1:0] rmag7, mmag7;
  digit_t             rmag, mmag;

  always_comb begin
    rneg    = radix_r[RADIX_W-1];
    mneg    = qmul_r[RADIX_W-1];
    rmag7   = rneg ? RADIX_W'(-radix_r) : radix_r;
    mmag7   = mneg ? RADIX_W'(-qmul_r) : qmul_r;
    cfg_bad = (rmag7 < RADIX_W'(2)) || (rmag7 > RADIX_W'(36)) || (mmag7 >= rmag7);
    rmag    = rmag7[DIG_W-1:0];
    mmag    = mmag7[DIG_W-1:0];
  end

  // ---------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------
  logic [2:0]       state_r, state_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;      // current quotient magnitude
  logic             neg_r, neg_nxt;      // sign of the current quotient
  logic             minus_r, minus_nxt;  // leading '-' pending
  logic [ND_W-1:0]  nd_r, nd_nxt;        // digits produced so far
  logic [AW-1:0]    idx_r, idx_nxt;      // read pointer, counts down
  logic [MAG_W-1:0] tm_r, tm_nxt;        // corrected quotient before multiply
  char_t            one_char_r, one_char_nxt;
  status_t          one_stat_r, one_stat_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  char_t            out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  status_t          out_stat_r, out_stat_nxt;
  logic             out_free;

  // shared divider
  logic             div_start, div_done;
  logic [MAG_W-1:0] div_quo;
  digit_t           div_rem;

  // digit buffer
  logic             buf_wr;
  digit_t           buf_wdata, buf_rdata;

  // request side helpers
  logic [MAG_W-1:0]        val_ext, in_mag;
  logic                    in_neg;
  logic [MAG_W-1:0]        q_fix;
  digit_t                  r_fix;
  logic                    ts;
  logic [MAG_W+DIG_W-1:0]  prod;
  logic [ND_W:0]           total;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    in_neg  = in_value[VALUE_WIDTH-1];
    val_ext = {{(MAG_W-VALUE_WIDTH){in_neg}}, in_value};
    in_mag  = in_neg ? MAG_W'(-val_ext) : val_ext;
    total   = {1'b0, nd_r} + (ND_W+1)'(minus_r);
    prod    = tm_r * mmag;

    // remainder correction for a negative running value
    q_fix = div_quo;
    r_fix = div_rem;
    ts    = neg_r ^ rneg;
    if (neg_r && (div_rem != '0)) begin
      r_fix = rmag - div_rem;
      if (!ts || (div_quo == '0)) begin
        q_fix = div_quo + MAG_W'(1);
        ts    = 1'b0;
      end else begin
        q_fix = div_quo - MAG_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    minus_nxt     = minus_r;
    nd_nxt        = nd_r;
    idx_nxt       = idx_r;
    tm_nxt        = tm_r;
    one_char_nxt  = one_char_r;
    one_stat_nxt  = one_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    div_start     = 1'b0;
    buf_wr        = 1'b0;
    buf_wdata     = r_fix;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          nd_nxt    = '0;
          mag_nxt   = in_mag;
          // positive base: sign goes out as '-', digits by magnitude
          minus_nxt = in_neg && !rneg;
          neg_nxt   = in_neg && rneg;
          if (cfg_bad) begin
            one_char_nxt = '0;
            one_stat_nxt = ST_BAD_CFG;
            state_nxt    = S_ONE;
          end else if (in_mag == '0) begin
            one_char_nxt = CH_ZERO;
            one_stat_nxt = ST_OK;
            state_nxt    = S_ONE;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (mag_r == '0) begin
          idx_nxt = AW'(nd_r - ND_W'(1));
          if (total > (ND_W+1)'(MAX_RESULTS)) begin
            one_char_nxt = '0;
            one_stat_nxt = ST_OVERFLOW;
            state_nxt    = S_ONE;
          end else if (minus_r) begin
            state_nxt = S_SIGN;
          end else begin
            state_nxt = S_RD;
          end
        end else if (nd_r == ND_W'(MAX_DIGITS)) begin
          // multiplier kept the quotient alive too long
          one_char_nxt = '0;
          one_stat_nxt = ST_OVERFLOW;
          state_nxt    = S_ONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          buf_wr    = 1'b1;
          nd_nxt    = nd_r + ND_W'(1);
          tm_nxt    = q_fix;
          neg_nxt   = ts ^ mneg;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        mag_nxt   = prod[MAG_W-1:0];
        state_nxt = S_CHECK;
      end

      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          out_stat_nxt  = ST_OK;
          state_nxt     = S_RD;
        end
      end

      S_RD: begin
        // buffer read data lands next cycle
        state_nxt = S_LD;
      end

      S_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_char(buf_rdata);
          out_last_nxt  = (idx_r == '0);
          out_stat_nxt  = ST_OK;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = S_RD;
          end
        end
      end

      S_ONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = one_char_r;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = one_stat_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    minus_r    <= minus_nxt;
    nd_r       <= nd_nxt;
    idx_r      <= idx_nxt;
    tm_r       <= tm_nxt;
    one_char_r <= one_char_nxt;
    one_stat_r <= one_stat_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_status     = out_stat_r;

  // ---------------------------------------------------------------------
  // shared divider and digit buffer
  // ---------------------------------------------------------------------
  ird_divider #(
    .W (MAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (rmag),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ird_digit_buf #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (nd_r[AW-1:0]),
    .wr_data (buf_wdata),
    .rd_addr (idx_r),
    .rd_data (buf_rdata)
  );

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `IRD_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)
  `IRD_ASSERT_IMPL(a_nd_bound, clk, rst_n, state_r == S_CHECK, nd_r <= ND_W'(MAX_DIGITS))
  `IRD_ASSERT_IMPL(a_err_single, clk, rst_n, out_valid_r && (out_stat_r != ST_OK),
                   out_last_r && (out_char_r == '0))

endmodule

`default_nettype wire
